### rtl/core/c6502ex_pkg.sv
// ----------------------------------------------------------------------------
// c6502ex_pkg
// Shared types, operation codes and flag positions for the 6502 execute
// stage (binary arithmetic only).
// ----------------------------------------------------------------------------
package c6502ex_pkg;

  // operation codes, alphabetical mnemonic order
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
    OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
    OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
    OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
  } op_t;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // reset values
  localparam logic [7:0] SP_RESET    = 8'hFF;
  localparam logic [7:0] FLAGS_RESET = 8'h20;

  typedef struct packed {
    logic [5:0] op;
    logic [7:0] operand;
    logic       to_memory;
  } in_item_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_data;
    logic       write_to_stack;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] flags_out;
  } out_item_t;

  // architectural register set
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } regs_t;

  // update N and Z from a result byte
  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] r;
    r         = p;
    r[FLAG_N] = v[7];
    r[FLAG_Z] = (v == 8'h00);
    return r;
  endfunction

endpackage

### rtl/core/c6502ex_regfile.sv
// ----------------------------------------------------------------------------
// c6502ex_regfile
// Architectural registers A, X, Y, S and P, loaded as each operation
// retires into the result register.
// ----------------------------------------------------------------------------
module c6502ex_regfile (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  c6502ex_pkg::regs_t  regs_next,
  output c6502ex_pkg::regs_t  regs
);

  // register set with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a <= 8'h00;
      regs.x <= 8'h00;
      regs.y <= 8'h00;
      regs.s <= c6502ex_pkg::SP_RESET;
      regs.p <= c6502ex_pkg::FLAGS_RESET;
    end else if (load) begin
      regs <= regs_next;
    end
  end

endmodule

### rtl/core/c6502ex_alu.sv
// ----------------------------------------------------------------------------
// c6502ex_alu
// Single-pass execute logic: decodes one operation, computes the new
// register set, the memory or stack write and the branch condition.
// ----------------------------------------------------------------------------
module c6502ex_alu (
  input  c6502ex_pkg::in_item_t  item,
  input  c6502ex_pkg::regs_t     regs,
  output c6502ex_pkg::regs_t     regs_next,
  output c6502ex_pkg::out_item_t result
);

  logic [7:0] m;
  logic [7:0] add_b;
  logic [8:0] add_sum;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_carry;
  logic       carry_in;
  logic       is_sbc;
  logic       we;
  logic       stk;
  logic       br;
  logic [7:0] wd;
  c6502ex_pkg::regs_t nr;

  assign m        = item.operand;
  assign carry_in = regs.p[c6502ex_pkg::FLAG_C];
  assign is_sbc   = (item.op == c6502ex_pkg::OP_SBC);

  // shared adder for ADC and SBC (SBC adds the inverted operand)
  assign add_b   = is_sbc ? ~m : m;
  assign add_sum = {1'b0, regs.a} + {1'b0, add_b} + {8'h00, carry_in};

  // compare subtractor, carry out means register >= operand
  always_comb begin
    case (item.op)
      c6502ex_pkg::OP_CPX: cmp_reg = regs.x;
      c6502ex_pkg::OP_CPY: cmp_reg = regs.y;
      default:             cmp_reg = regs.a;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} + {1'b0, ~m} + 9'd1;

  // shifter and rotator
  assign sh_src = item.to_memory ? m : regs.a;
  always_comb begin
    case (item.op)
      c6502ex_pkg::OP_ASL: begin
        sh_res   = {sh_src[6:0], 1'b0};
        sh_carry = sh_src[7];
      end
      c6502ex_pkg::OP_ROL: begin
        sh_res   = {sh_src[6:0], carry_in};
        sh_carry = sh_src[7];
      end
      c6502ex_pkg::OP_LSR: begin
        sh_res   = {1'b0, sh_src[7:1]};
        sh_carry = sh_src[0];
      end
      c6502ex_pkg::OP_ROR: begin
        sh_res   = {carry_in, sh_src[7:1]};
        sh_carry = sh_src[0];
      end
      default: begin
        sh_res   = sh_src;
        sh_carry = carry_in;
      end
    endcase
  end

  // operation decode
  always_comb begin
    nr  = regs;
    we  = 1'b0;
    stk = 1'b0;
    br  = 1'b0;
    wd  = 8'h00;
    case (item.op)
      c6502ex_pkg::OP_ADC: begin
        nr.a = add_sum[7:0];
        nr.p = c6502ex_pkg::set_nz(regs.p, add_sum[7:0]);
        nr.p[c6502ex_pkg::FLAG_C] = add_sum[8];
        nr.p[c6502ex_pkg::FLAG_V] = ~(regs.a[7] ^ m[7]) & (regs.a[7] ^ add_sum[7]);
      end
      c6502ex_pkg::OP_SBC: begin
        nr.a = add_sum[7:0];
        nr.p = c6502ex_pkg::set_nz(regs.p, add_sum[7:0]);
        nr.p[c6502ex_pkg::FLAG_C] = add_sum[8];
        nr.p[c6502ex_pkg::FLAG_V] = (regs.a[7] ^ m[7]) & (regs.a[7] ^ add_sum[7]);
      end
      c6502ex_pkg::OP_AND: begin
        nr.a = regs.a & m;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.a & m);
      end
      c6502ex_pkg::OP_EOR: begin
        nr.a = regs.a ^ m;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.a ^ m);
      end
      c6502ex_pkg::OP_ORA: begin
        nr.a = regs.a | m;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.a | m);
      end
      c6502ex_pkg::OP_ASL, c6502ex_pkg::OP_LSR,
      c6502ex_pkg::OP_ROL, c6502ex_pkg::OP_ROR: begin
        nr.p = c6502ex_pkg::set_nz(regs.p, sh_res);
        nr.p[c6502ex_pkg::FLAG_C] = sh_carry;
        if (item.to_memory) begin
          we = 1'b1;
          wd = sh_res;
        end else begin
          nr.a = sh_res;
        end
      end
      c6502ex_pkg::OP_BCC: br = ~regs.p[c6502ex_pkg::FLAG_C];
      c6502ex_pkg::OP_BCS: br = regs.p[c6502ex_pkg::FLAG_C];
      c6502ex_pkg::OP_BEQ: br = regs.p[c6502ex_pkg::FLAG_Z];
      c6502ex_pkg::OP_BMI: br = regs.p[c6502ex_pkg::FLAG_N];
      c6502ex_pkg::OP_BNE: br = ~regs.p[c6502ex_pkg::FLAG_Z];
      c6502ex_pkg::OP_BPL: br = ~regs.p[c6502ex_pkg::FLAG_N];
      c6502ex_pkg::OP_BVC: br = ~regs.p[c6502ex_pkg::FLAG_V];
      c6502ex_pkg::OP_BVS: br = regs.p[c6502ex_pkg::FLAG_V];
      c6502ex_pkg::OP_BIT: begin
        nr.p[c6502ex_pkg::FLAG_V] = m[6];
        nr.p[c6502ex_pkg::FLAG_N] = m[7];
        nr.p[c6502ex_pkg::FLAG_Z] = ((regs.a & m) == 8'h00);
      end
      c6502ex_pkg::OP_BRK: begin
        nr.p[c6502ex_pkg::FLAG_B] = 1'b1;
        nr.p[c6502ex_pkg::FLAG_I] = 1'b1;
      end
      c6502ex_pkg::OP_CLC: nr.p[c6502ex_pkg::FLAG_C] = 1'b0;
      c6502ex_pkg::OP_CLD: nr.p[c6502ex_pkg::FLAG_D] = 1'b0;
      c6502ex_pkg::OP_CLI: nr.p[c6502ex_pkg::FLAG_I] = 1'b0;
      c6502ex_pkg::OP_CLV: nr.p[c6502ex_pkg::FLAG_V] = 1'b0;
      c6502ex_pkg::OP_SEC: nr.p[c6502ex_pkg::FLAG_C] = 1'b1;
      c6502ex_pkg::OP_SED: nr.p[c6502ex_pkg::FLAG_D] = 1'b1;
      c6502ex_pkg::OP_SEI: nr.p[c6502ex_pkg::FLAG_I] = 1'b1;
      c6502ex_pkg::OP_CMP, c6502ex_pkg::OP_CPX, c6502ex_pkg::OP_CPY: begin
        nr.p = c6502ex_pkg::set_nz(regs.p, cmp_diff[7:0]);
        nr.p[c6502ex_pkg::FLAG_C] = cmp_diff[8];
      end
      c6502ex_pkg::OP_DEC: begin
        wd   = m - 8'd1;
        we   = 1'b1;
        nr.p = c6502ex_pkg::set_nz(regs.p, m - 8'd1);
      end
      c6502ex_pkg::OP_INC: begin
        wd   = m + 8'd1;
        we   = 1'b1;
        nr.p = c6502ex_pkg::set_nz(regs.p, m + 8'd1);
      end
      c6502ex_pkg::OP_DEX: begin
        nr.x = regs.x - 8'd1;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.x - 8'd1);
      end
      c6502ex_pkg::OP_DEY: begin
        nr.y = regs.y - 8'd1;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.y - 8'd1);
      end
      c6502ex_pkg::OP_INX: begin
        nr.x = regs.x + 8'd1;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.x + 8'd1);
      end
      c6502ex_pkg::OP_INY: begin
        nr.y = regs.y + 8'd1;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.y + 8'd1);
      end
      c6502ex_pkg::OP_LDA: begin
        nr.a = m;
        nr.p = c6502ex_pkg::set_nz(regs.p, m);
      end
      c6502ex_pkg::OP_LDX: begin
        nr.x = m;
        nr.p = c6502ex_pkg::set_nz(regs.p, m);
      end
      c6502ex_pkg::OP_LDY: begin
        nr.y = m;
        nr.p = c6502ex_pkg::set_nz(regs.p, m);
      end
      c6502ex_pkg::OP_PHA: begin
        we   = 1'b1;
        stk  = 1'b1;
        wd   = regs.a;
        nr.s = regs.s - 8'd1;
      end
      c6502ex_pkg::OP_PHP: begin
        we   = 1'b1;
        stk  = 1'b1;
        wd   = regs.p;
        wd[c6502ex_pkg::FLAG_B] = 1'b1;
        nr.s = regs.s - 8'd1;
      end
      c6502ex_pkg::OP_PLA: begin
        nr.s = regs.s + 8'd1;
        nr.a = m;
        nr.p = c6502ex_pkg::set_nz(regs.p, m);
      end
      c6502ex_pkg::OP_PLP: begin
        nr.s = regs.s + 8'd1;
        nr.p = m;
        nr.p[c6502ex_pkg::FLAG_U] = 1'b1;
      end
      c6502ex_pkg::OP_RTI: begin
        nr.p = m;
        nr.p[c6502ex_pkg::FLAG_U] = 1'b1;
      end
      c6502ex_pkg::OP_STA: begin
        we = 1'b1;
        wd = regs.a;
      end
      c6502ex_pkg::OP_STX: begin
        we = 1'b1;
        wd = regs.x;
      end
      c6502ex_pkg::OP_STY: begin
        we = 1'b1;
        wd = regs.y;
      end
      c6502ex_pkg::OP_TAX: begin
        nr.x = regs.a;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.a);
      end
      c6502ex_pkg::OP_TAY: begin
        nr.y = regs.a;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.a);
      end
      c6502ex_pkg::OP_TSX: begin
        nr.x = regs.s;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.s);
      end
      c6502ex_pkg::OP_TXA: begin
        nr.a = regs.x;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.x);
      end
      c6502ex_pkg::OP_TXS: nr.s = regs.x;
      c6502ex_pkg::OP_TYA: begin
        nr.a = regs.y;
        nr.p = c6502ex_pkg::set_nz(regs.p, regs.y);
      end
      // jumps, RTS, no-op and unassigned codes leave everything alone
      default: nr = regs;
    endcase
  end

  // result assembly
  assign regs_next = nr;
  always_comb begin
    result.write_enable   = we;
    result.write_data     = wd;
    result.write_to_stack = stk;
    result.branch_taken   = br;
    result.acc_out        = nr.a;
    result.x_out          = nr.x;
    result.y_out          = nr.y;
    result.sp_out         = nr.s;
    result.flags_out      = nr.p;
  end

endmodule

### rtl/core/cpu6502_execute_alu_flags.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_alu_flags
// 6502 execute stage without decimal mode: input register, single-pass
// execute logic, result register and the A/X/Y/S/P register set.
// The result register loads when the operation in the input register retires.
// Throughput: one operation per cycle unless out_stall holds the result;
//   the register set is read by the operation in the input register and
//   written as it moves to the result.
// Reset: synchronous; A, X, Y = 0, S = 0xFF, P = 0x20; both stages empty.
// ----------------------------------------------------------------------------
module cpu6502_execute_alu_flags (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  c6502ex_pkg::in_item_t     in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output c6502ex_pkg::out_item_t    out_item
);

  logic                   stage_valid;
  c6502ex_pkg::in_item_t  stage_item;
  logic                   advance;
  c6502ex_pkg::regs_t     regs;
  c6502ex_pkg::regs_t     regs_next;
  c6502ex_pkg::out_item_t alu_result;

  // an operation retires when the result register is free or being drained
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      stage_item <= in_item;
    end
  end

  // execute logic
  c6502ex_alu u_alu (
    .item      (stage_item),
    .regs      (regs),
    .regs_next (regs_next),
    .result    (alu_result)
  );

  // architectural registers
  c6502ex_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .regs_next (regs_next),
    .regs      (regs)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= alu_result;
    end
  end

endmodule
